// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the stable sorted priority queue.
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  new_value;
    logic signed [DATA_W-1:0]  new_prio;
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One storage cell of the sorted chain: holds an entry and trades it with its neighbours.
module spq_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  spq_pkg::cell_ctrl_t                 ctrl,
  input  logic                                left_valid,
  input  logic signed [spq_pkg::DATA_W-1:0]   left_value,
  input  logic signed [spq_pkg::DATA_W-1:0]   left_prio,
  input  logic                                left_le,
  input  logic                                right_valid,
  input  logic signed [spq_pkg::DATA_W-1:0]   right_value,
  input  logic signed [spq_pkg::DATA_W-1:0]   right_prio,
  input  logic signed [spq_pkg::DATA_W-1:0]   head_value,
  input  logic signed [spq_pkg::DATA_W-1:0]   head_prio,
  output logic                                valid,
  output logic signed [spq_pkg::DATA_W-1:0]   ent_value,
  output logic signed [spq_pkg::DATA_W-1:0]   ent_prio,
  output logic                                le
);
  import spq_pkg::*;

  logic                     valid_next;
  logic signed [DATA_W-1:0] ent_value_next;
  logic signed [DATA_W-1:0] ent_prio_next;

  assign le = valid && (ent_prio <= ctrl.new_prio);

  always_comb begin
    valid_next     = valid;
    ent_value_next = ent_value;
    ent_prio_next  = ent_prio;
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_INSERT: begin
        if (le) begin
        end else if (left_le) begin
          valid_next     = 1'b1;
          ent_value_next = ctrl.new_value;
          ent_prio_next  = ctrl.new_prio;
        end else begin
          valid_next     = left_valid;
          ent_value_next = left_value;
          ent_prio_next  = left_prio;
        end
      end
      OP_REMOVE: begin
        valid_next     = right_valid;
        ent_value_next = right_value;
        ent_prio_next  = right_prio;
      end
      OP_ROTATE: begin
        if (right_valid) begin
          ent_value_next = right_value;
          ent_prio_next  = right_prio;
        end else if (valid) begin
          ent_value_next = head_value;
          ent_prio_next  = head_prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ent_value <= ent_value_next;
    ent_prio  <= ent_prio_next;
  end

endmodule

// ===== rtl/stable_sorted_priority_queue_core.sv =====
// Top level: stable sorted priority queue built as a chain of cells.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid, in_stall | cmd, item_value, priority_req
//  out     | out_valid,out_stall| status, out_value, out_priority, last
//
// Insert and remove give one beat each; a new beat may follow every cycle when not stalled.
// A list enters the list state, then gives one beat per entry; input is stalled
// until its last beat is registered. The chain rotates one place per beat.
// Reset empties the queue; stored values are not cleared.
// The input stalls while the output register holds a beat that is stalled.
module stable_sorted_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [spq_pkg::CMD_W-1:0]          cmd,
  input  logic signed [spq_pkg::DATA_W-1:0]  item_value,
  input  logic signed [spq_pkg::DATA_W-1:0]  priority_req,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [spq_pkg::STAT_W-1:0]         status,
  output logic signed [spq_pkg::DATA_W-1:0]  out_value,
  output logic signed [spq_pkg::DATA_W-1:0]  out_priority,
  output logic                               last
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t                   state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            remain, remain_next;
  cell_ctrl_t               ctrl;
  logic [QUEUE_DEPTH-1:0]   cell_valid;
  logic [QUEUE_DEPTH-1:0]   cell_le;
  logic signed [DATA_W-1:0] cell_value [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] cell_prio  [QUEUE_DEPTH];

  logic                     accept;
  logic                     load_ok;
  logic                     emit;
  status_t                  emit_status;
  logic signed [DATA_W-1:0] emit_value;
  logic signed [DATA_W-1:0] emit_prio;
  logic                     emit_last;
  logic                     full;
  logic                     empty;

  assign full    = cell_valid[QUEUE_DEPTH-1];
  assign empty   = !cell_valid[0];
  assign load_ok = !out_valid || !out_stall;
  assign in_stall = (state == S_LIST) || !load_ok;
  assign accept  = in_valid && !in_stall;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                     l_valid, l_le, r_valid;
      logic signed [DATA_W-1:0] l_value, l_prio, r_value, r_prio;
      if (g == 0) begin : g_first
        assign l_valid = 1'b0;
        assign l_le    = 1'b1;
        assign l_value = '0;
        assign l_prio  = '0;
      end else begin : g_mid
        assign l_valid = cell_valid[g-1];
        assign l_le    = cell_le[g-1];
        assign l_value = cell_value[g-1];
        assign l_prio  = cell_prio[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_end
        assign r_valid = 1'b0;
        assign r_value = '0;
        assign r_prio  = '0;
      end else begin : g_inner
        assign r_valid = cell_valid[g+1];
        assign r_value = cell_value[g+1];
        assign r_prio  = cell_prio[g+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .left_valid  (l_valid),
        .left_value  (l_value),
        .left_prio   (l_prio),
        .left_le     (l_le),
        .right_valid (r_valid),
        .right_value (r_value),
        .right_prio  (r_prio),
        .head_value  (cell_value[0]),
        .head_prio   (cell_prio[0]),
        .valid       (cell_valid[g]),
        .ent_value   (cell_value[g]),
        .ent_prio    (cell_prio[g]),
        .le          (cell_le[g])
      );
    end
  endgenerate

  always_comb begin
    state_next     = state;
    count_next     = count;
    remain_next    = remain;
    ctrl.op        = OP_HOLD;
    ctrl.new_value = item_value;
    ctrl.new_prio  = priority_req;
    emit           = 1'b0;
    emit_status    = STAT_OK;
    emit_value     = '0;
    emit_prio      = '0;
    emit_last      = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_INSERT: begin
              emit = 1'b1;
              if (full) begin
                emit_status = STAT_FULL;
              end else begin
                ctrl.op    = OP_INSERT;
                count_next = count + CW'(1);
              end
            end
            CMD_REMOVE: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = STAT_EMPTY;
              end else begin
                emit_value = cell_value[0];
                emit_prio  = cell_prio[0];
                ctrl.op    = OP_REMOVE;
                count_next = count - CW'(1);
              end
            end
            CMD_LIST: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                state_next  = S_LIST;
                remain_next = count;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        if (load_ok) begin
          emit        = 1'b1;
          emit_value  = cell_value[0];
          emit_prio   = cell_prio[0];
          emit_last   = (remain == CW'(1));
          ctrl.op     = OP_ROTATE;
          remain_next = remain - CW'(1);
          if (remain == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      if (load_ok) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && emit) begin
      status       <= emit_status;
      out_value    <= emit_value;
      out_priority <= emit_prio;
      last         <= emit_last;
    end
  end

  a_thermometer: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(count))
    else $error("entry count disagrees with occupied cells");

  a_remain: assert property (@(posedge clk) disable iff (rst)
    state == S_LIST |-> remain != '0 && remain <= count)
    else $error("list countdown out of range");

  a_list_end: assert property (@(posedge clk) disable iff (rst)
    $past(state == S_LIST) && state == S_IDLE |-> out_valid && last)
    else $error("list ended without a final beat");

endmodule

// ===== verif/stable_sorted_priority_queue_core_tb.sv =====
// Testbench for the stable sorted priority queue: directed and random commands, shadow-queue check.
`timescale 1ns / 100ps

module stable_sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int DEPTH = 16;
  localparam int LIMIT = 200000;
  localparam int SETTLE = 40;
  localparam int RANDOM_BEATS = 430;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic                     last;
  } beat_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         cmd = CMD_INSERT;
  logic signed [DATA_W-1:0] item_value = '0;
  logic signed [DATA_W-1:0] priority_req = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] out_value;
  logic signed [DATA_W-1:0] out_priority;
  logic                     last;

  logic signed [DATA_W-1:0] shadow_value [DEPTH];
  logic signed [DATA_W-1:0] shadow_prio [DEPTH];
  int                       shadow_count = 0;
  beat_t                    pending_beats [$];
  int                       errors = 0;
  int                       cycles = 0;
  bit                       steady = 1'b0;

  stable_sorted_priority_queue_core #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .item_value(item_value),
    .priority_req(priority_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .out_value(out_value),
    .out_priority(out_priority),
    .last(last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL stable_sorted_priority_queue_core");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 37);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 100) begin
      $display("mismatch: %s got %0h expected %0h (cycle %0d)", what, got, want, cycles);
    end
  endtask

  // Work out the beats one command yields and update the shadow queue.
  task automatic predict_command(input logic [CMD_W-1:0] op,
                                 input logic signed [DATA_W-1:0] val,
                                 input logic signed [DATA_W-1:0] pri);
    beat_t b;
    int    pos;
    int    j;
    b.status = STAT_OK;
    b.value = '0;
    b.prio = '0;
    b.last = 1'b1;
    case (op)
      CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          b.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] <= pri) pos++;
          for (j = shadow_count; j > pos; j--) begin
            shadow_value[j] = shadow_value[j-1];
            shadow_prio[j] = shadow_prio[j-1];
          end
          shadow_value[pos] = val;
          shadow_prio[pos] = pri;
          shadow_count++;
        end
        pending_beats.push_back(b);
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          b.status = STAT_EMPTY;
        end else begin
          b.value = shadow_value[0];
          b.prio = shadow_prio[0];
          for (j = 1; j < shadow_count; j++) begin
            shadow_value[j-1] = shadow_value[j];
            shadow_prio[j-1] = shadow_prio[j];
          end
          shadow_count--;
        end
        pending_beats.push_back(b);
      end
      CMD_LIST: begin
        if (shadow_count == 0) begin
          b.status = STAT_EMPTY;
          pending_beats.push_back(b);
        end else begin
          for (j = 0; j < shadow_count; j++) begin
            b.value = shadow_value[j];
            b.prio = shadow_prio[j];
            b.last = (j == shadow_count - 1);
            pending_beats.push_back(b);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [CMD_W-1:0] op,
                           input logic signed [DATA_W-1:0] val,
                           input logic signed [DATA_W-1:0] pri);
    while (!steady && $urandom_range(99) < 37) begin
      in_valid = 1'b0;
      cmd = CMD_W'($urandom);
      item_value = $urandom;
      priority_req = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = op;
    item_value = val;
    priority_req = pri;
    do @(posedge clk); while (in_stall);
    predict_command(op, val, pri);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_priority();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(4);
      2: return -$signed(DATA_W'($urandom_range(3)));
      default: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
  endfunction

  task automatic test_empty_queue();
    send_beat(CMD_REMOVE, 32'sh7FFFFFFF, 32'sh80000000);
    send_beat(CMD_LIST, 32'sh80000000, 32'sh7FFFFFFF);
    send_beat(CMD_UNUSED, -32'sd1, -32'sd1);
    wait_for_results();
  endtask

  task automatic test_fill_to_full();
    logic signed [DATA_W-1:0] pri_tab [DEPTH] = '{
      32'sh7FFFFFFF, 32'sh80000000, 0, -1, 0, 1, 32'sh80000000, 32'sh7FFFFFFF,
      -1, 5, 5, 5, 32'sh55555555, 32'shAAAAAAAA, 0, 2};
    logic signed [DATA_W-1:0] val_tab [DEPTH] = '{
      32'sh80000000, 32'sh7FFFFFFF, 0, -1, 32'sh55555555, 32'shAAAAAAAA, 6, 7,
      8, 9, 10, 11, 12, 13, 14, 15};
    int i;
    for (i = 0; i < DEPTH; i++) send_beat(CMD_INSERT, val_tab[i], pri_tab[i]);
    send_beat(CMD_INSERT, 32'sh12345678, 32'sh80000000);
    send_beat(CMD_LIST, 0, 0);
    wait_for_results();
  endtask

  task automatic test_remove_front();
    send_beat(CMD_REMOVE, 0, 0);
    send_beat(CMD_REMOVE, 0, 0);
    send_beat(CMD_REMOVE, 0, 0);
    wait_for_results();
  endtask

  task automatic test_random_mix();
    int n;
    int r;
    int insert_weight;
    insert_weight = 50;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 45 == 0) insert_weight = $urandom_range(15, 85);
      steady = (n >= 150 && n < 250);
      if (n == 300) wait_for_results();
      r = $urandom_range(99);
      if (r < 3) begin
        send_beat(CMD_UNUSED, $urandom, $urandom);
      end else if (r < 13) begin
        send_beat(CMD_LIST, $urandom, $urandom);
      end else if ($urandom_range(99) < insert_weight) begin
        send_beat(CMD_INSERT, $urandom, pick_priority());
      end else begin
        send_beat(CMD_REMOVE, $urandom, $urandom);
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin : check_out
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing expected", 64'(out_value), 64'd0);
      end else begin
        want = pending_beats.pop_front();
        if (status !== want.status) begin
          report_mismatch("status", 64'(status), 64'(want.status));
        end
        if (out_value !== want.value) begin
          report_mismatch("out_value", 64'(out_value), 64'(want.value));
        end
        if (out_priority !== want.prio) begin
          report_mismatch("out_priority", 64'(out_priority), 64'(want.prio));
        end
        if (last !== want.last) begin
          report_mismatch("last", 64'(last), 64'(want.last));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_queue();
    test_fill_to_full();
    test_remove_front();
    test_random_mix();
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("PASS stable_sorted_priority_queue_core");
    end else begin
      $display("FAIL stable_sorted_priority_queue_core");
    end
    $finish;
  end

endmodule
